// File: rtl/core/bdeque_pkg.sv
`default_nettype none
package bdeque_pkg;

   // storage geometry
   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int COUNT_W    = $clog2(CAPACITY + 1);

   // port widths fixed by the interface
   localparam int OP_W     = 3;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_PUSH_HEAD = 3'd0,
      OP_PUSH_TAIL = 3'd1,
      OP_POP_HEAD  = 3'd2,
      OP_POP_TAIL  = 3'd3,
      OP_PEEK_HEAD = 3'd4,
      OP_PEEK_TAIL = 3'd5,
      OP_SEARCH    = 3'd6
   } op_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // which ring position a read targets
   typedef enum logic [1:0] {
      RD_HEAD   = 2'd0,
      RD_TAIL   = 2'd1,
      RD_SEARCH = 2'd2
   } rd_sel_type;

   // controller to datapath
   typedef struct packed {
      logic       capture;
      logic       wr_en;
      logic       push_head;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       iter_inc;
      logic       pop_head;
      logic       pop_tail;
      logic       rsp_load;
      status_type rsp_status;
      logic       rsp_use_data;
      logic       rsp_found;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
      logic   full;
      logic   empty;
      logic   match;
      logic   last;
      logic   out_free;
   } sts_type;

endpackage
`default_nettype wire

// File: rtl/core/bounded_deque_with_search_top.sv
// push, unused code, empty pop/peek: result loaded in exec; pop and peek load it after a read wait
// search: one entry compared per cycle, ends early on a match
// throughput: one word in flight; the next is accepted once the result is loaded, even while it waits
// reset: synchronous active-high, empties the queue (head and count to zero, no result pending)
// the entry ram is not cleared; only held entries are ever read
`default_nettype none
module bounded_deque_with_search_top
   import bdeque_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [OP_W-1:0]     req_operation,
   input  wire logic [WORD_W-1:0]   req_value,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [WORD_W-1:0]        rsp_data_out,
   output logic                     rsp_found,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [COUNT_W-1:0]       rsp_count
);

   cmd_type cmd;
   sts_type sts;

   // sequencer
   bdeque_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // ring store and result register
   bdeque_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_operation (req_operation),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data_out  (rsp_data_out),
      .rsp_found     (rsp_found),
      .rsp_status    (rsp_status),
      .rsp_count     (rsp_count)
   );

endmodule
`default_nettype wire

// File: rtl/core/bdeque_ctrl.sv
`default_nettype none
module bdeque_ctrl
   import bdeque_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_RDWAIT,
      S_SEARCH
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in         = state_ff;
      cmd              = '0;
      cmd.rd_sel       = RD_HEAD;
      cmd.rsp_status   = ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            case (sts.op)
               OP_PUSH_HEAD, OP_PUSH_TAIL: begin
                  if (sts.out_free) begin
                     cmd.rsp_load = 1'b1;
                     if (sts.full) begin
                        cmd.rsp_status = ST_FULL;
                     end else begin
                        cmd.wr_en     = 1'b1;
                        cmd.push_head = (sts.op == OP_PUSH_HEAD);
                     end
                     state_in = S_IDLE;
                  end
               end
               OP_POP_HEAD, OP_POP_TAIL, OP_PEEK_HEAD, OP_PEEK_TAIL: begin
                  if (sts.empty) begin
                     if (sts.out_free) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = ST_EMPTY;
                        state_in       = S_IDLE;
                     end
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = (sts.op == OP_POP_HEAD || sts.op == OP_PEEK_HEAD) ?
                                  RD_HEAD : RD_TAIL;
                     state_in   = S_RDWAIT;
                  end
               end
               OP_SEARCH: begin
                  if (sts.empty) begin
                     if (sts.out_free) begin
                        cmd.rsp_load = 1'b1;
                        state_in     = S_IDLE;
                     end
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_SEARCH;
                     state_in   = S_SEARCH;
                  end
               end
               default: begin
                  // unused code: plain ok result
                  if (sts.out_free) begin
                     cmd.rsp_load = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
            endcase
         end
         S_RDWAIT: begin
            if (sts.out_free) begin
               cmd.rsp_load     = 1'b1;
               cmd.rsp_use_data = 1'b1;
               cmd.pop_head     = (sts.op == OP_POP_HEAD);
               cmd.pop_tail     = (sts.op == OP_POP_TAIL);
               state_in         = S_IDLE;
            end
         end
         S_SEARCH: begin
            if (sts.match || sts.last) begin
               if (sts.out_free) begin
                  cmd.rsp_load  = 1'b1;
                  cmd.rsp_found = sts.match;
                  state_in      = S_IDLE;
               end
            end else begin
               // fetch the next held entry
               cmd.iter_inc = 1'b1;
               cmd.rd_en    = 1'b1;
               cmd.rd_sel   = RD_SEARCH;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/bdeque_dp.sv
`default_nettype none
module bdeque_dp
   import bdeque_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output sts_type                  sts,
   input  wire logic [OP_W-1:0]     req_operation,
   input  wire logic [WORD_W-1:0]   req_value,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [WORD_W-1:0]        rsp_data_out,
   output logic                     rsp_found,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [COUNT_W-1:0]       rsp_count
);

   // ring position plus offset, offset at most CAPACITY
   function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] pos,
                                                  input logic [COUNT_W-1:0] off);
      logic [COUNT_W:0] sum;
      sum = (COUNT_W+1)'(pos) + (COUNT_W+1)'(off);
      if (sum >= (COUNT_W+1)'(CAPACITY)) begin
         sum = sum - (COUNT_W+1)'(CAPACITY);
      end
      return sum[ADDR_W-1:0];
   endfunction

   logic [DATA_WIDTH-1:0] mem [CAPACITY];

   op_type                op_ff;
   logic [DATA_WIDTH-1:0] word_ff;
   logic [ADDR_W-1:0]     head_ff;
   logic [ADDR_W-1:0]     head_in;
   logic [COUNT_W-1:0]    count_ff;
   logic [COUNT_W-1:0]    count_in;
   logic [ADDR_W-1:0]     iter_ff;
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic [ADDR_W-1:0]     head_prev;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ADDR_W-1:0]     rd_addr;
   logic [COUNT_W-1:0]    srch_off;
   logic                  rsp_valid_ff;
   logic [WORD_W-1:0]     rsp_data_ff;
   logic                  rsp_found_ff;
   status_type            rsp_status_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   // ring addressing
   always_comb begin
      head_prev = (head_ff == '0) ? ADDR_W'(CAPACITY - 1) : head_ff - 1'b1;
      wr_addr   = cmd.push_head ? head_prev : ring_add(head_ff, count_ff);
      srch_off  = COUNT_W'(iter_ff) + COUNT_W'(cmd.iter_inc);
      case (cmd.rd_sel)
         RD_HEAD:   rd_addr = head_ff;
         RD_TAIL:   rd_addr = ring_add(head_ff, count_ff - 1'b1);
         RD_SEARCH: rd_addr = ring_add(head_ff, srch_off);
         default:   rd_addr = head_ff;
      endcase
   end

   // next head and count
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.wr_en) begin
         count_in = count_ff + 1'b1;
         if (cmd.push_head) begin
            head_in = head_prev;
         end
      end
      if (cmd.pop_head) begin
         head_in  = ring_add(head_ff, COUNT_W'(1));
         count_in = count_ff - 1'b1;
      end
      if (cmd.pop_tail) begin
         count_in = count_ff - 1'b1;
      end
   end

   // status back to the controller
   always_comb begin
      sts.op       = op_ff;
      sts.full     = (count_ff == COUNT_W'(CAPACITY));
      sts.empty    = (count_ff == '0);
      sts.match    = (rd_data_ff == word_ff);
      sts.last     = (COUNT_W'(iter_ff) == count_ff - 1'b1);
      sts.out_free = !rsp_valid_ff || rsp_ready;
   end

   // entry store
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= word_ff;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // captured request word and search index
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= op_type'(req_operation);
         word_ff <= req_value[DATA_WIDTH-1:0];
         iter_ff <= '0;
      end else if (cmd.iter_inc) begin
         iter_ff <= iter_ff + 1'b1;
      end
   end

   // ring pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff   <= cmd.rsp_use_data ? WORD_W'(rd_data_ff) : '0;
         rsp_found_ff  <= cmd.rsp_found;
         rsp_status_ff <= cmd.rsp_status;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_count    = rsp_count_ff;

endmodule
`default_nettype wire
